### rtl/rau_pkg.sv
// Package for the rational arithmetic unit: payload structs, op codes, constants.
// No dependencies.
package rau_pkg;

    localparam int OPW_DEFAULT = 32;
    localparam int MAGW        = 64;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } t_in;

    typedef struct packed {
        logic signed [63:0] res_num;
        logic [62:0]        res_den;
        logic               div_error;
    } t_out;

    // classified item handed from front to back
    typedef struct packed {
        logic [1:0]  func;
        logic        err;
        logic        sa;
        logic        sb;
        logic [31:0] na;
        logic [31:0] da;
        logic [31:0] nb;
        logic [31:0] db;
    } t_job;

endpackage

### rtl/rau_front.sv
// Front end: sign-extends operands, takes magnitudes and signs, flags zero
// denominators and division by zero, and queues classified jobs. Depends on rau_pkg.
module rau_front
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPW_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_in  i_data,
    output logic o_full,
    output logic o_jvalid,
    output t_job o_job,
    input  logic i_jtake
);
    localparam int DEPTH = 2;

    t_job r_q [DEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_job       w_job;

    function automatic logic [32:0] ext(input logic [31:0] raw);
        logic [31:0] v;
        logic        neg;
        v   = {{(32-OPERAND_WIDTH){raw[OPERAND_WIDTH-1]}}, raw[OPERAND_WIDTH-1:0]};
        neg = v[31];
        return {neg, neg ? (32'd0 - v) : v};
    endfunction

    logic [32:0] w_an, w_ad, w_bn, w_bd;

    always_comb begin
        w_an = ext(i_data.a_num);
        w_ad = ext(i_data.a_den);
        w_bn = ext(i_data.b_num);
        w_bd = ext(i_data.b_den);
        w_job.func = i_data.func;
        w_job.na   = w_an[31:0];
        w_job.da   = w_ad[31:0];
        w_job.nb   = w_bn[31:0];
        w_job.db   = w_bd[31:0];
        w_job.sa   = w_an[32] ^ w_ad[32];
        w_job.sb   = (w_bn[32] ^ w_bd[32]) ^ (i_data.func == OP_SUB);
        w_job.err  = (w_ad[31:0] == '0) || (w_bd[31:0] == '0) ||
                     ((i_data.func == OP_DIV) && (w_bn[31:0] == '0));
    end

    logic w_wr, w_rd;
    assign o_full   = (r_cnt == 2'(DEPTH));
    assign w_wr     = i_push && !o_full;
    assign o_jvalid = (r_cnt != '0);
    assign w_rd     = i_jtake && o_jvalid;
    assign o_job    = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= w_job;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end
endmodule

### rtl/rau_divider.sv
// 64-bit unsigned restoring divider, one quotient bit per cycle.
// Depends on rau_pkg.
module rau_divider
    import rau_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [MAGW-1:0] i_dvd,
    input  logic [MAGW-1:0] i_dvs,
    output logic            o_done,
    output logic [MAGW-1:0] o_quo
);
    logic [MAGW-1:0] r_q, r_r, r_d;
    logic [6:0]      r_cnt;
    logic            r_busy;
    logic [MAGW:0]   w_sh, w_diff;

    assign w_sh   = {r_r, r_q[MAGW-1]};
    assign w_diff = w_sh - {1'b0, r_d};
    assign o_quo  = r_q;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dvd;
            r_r <= '0;
            r_d <= i_dvs;
        end else if (r_busy) begin
            if (!w_diff[MAGW]) begin
                r_r <= w_diff[MAGW-1:0];
                r_q <= {r_q[MAGW-2:0], 1'b1};
            end else begin
                r_r <= w_sh[MAGW-1:0];
                r_q <= {r_q[MAGW-2:0], 1'b0};
            end
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'(MAGW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

### rtl/rau_back.sv
// Back end: sequencer that computes the combined fraction and reduces it by a
// binary GCD and two divisions. Depends on rau_pkg and rau_divider.
module rau_back
    import rau_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_jvalid,
    input  t_job i_job,
    output logic o_jtake,
    output logic o_empty,
    output t_out o_data,
    input  logic i_pop
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_G1    = 4'd1;
    localparam logic [3:0] S_DV1   = 4'd2;
    localparam logic [3:0] S_M1    = 4'd3;
    localparam logic [3:0] S_M2    = 4'd4;
    localparam logic [3:0] S_G2    = 4'd5;
    localparam logic [3:0] S_DVN   = 4'd6;
    localparam logic [3:0] S_DVD   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_WAITD = 4'd9;

    logic [3:0]      r_st;
    t_job            r_job;
    logic [MAGW-1:0] r_x, r_y, r_g, r_mag, r_den, r_t1, r_q1;
    logic [6:0]      r_k;
    logic            r_neg;
    logic            r_ov;
    t_out            r_res;   // result being built, moved out in S_OUT
    t_out            r_out;
    logic            r_dstart;
    logic [MAGW-1:0] r_dvd, r_dvs;
    logic            w_ddone;
    logic [MAGW-1:0] w_quo;

    rau_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_dstart),
        .i_dvd  (r_dvd),
        .i_dvs  (r_dvs),
        .o_done (w_ddone),
        .o_quo  (w_quo)
    );

    assign o_empty = !r_ov;
    assign o_data  = r_out;
    assign o_jtake = (r_st == S_IDLE) && i_jvalid;

    // binary GCD step: one step per cycle
    logic [MAGW-1:0] w_gx, w_gy;
    logic [6:0]      w_gk;
    logic            w_gdone;
    always_comb begin
        w_gx = r_x; w_gy = r_y; w_gk = r_k; w_gdone = 1'b0;
        if (r_y == '0) begin
            w_gdone = 1'b1;
        end else if (!r_x[0] && !r_y[0]) begin
            w_gx = r_x >> 1; w_gy = r_y >> 1; w_gk = r_k + 7'd1;
        end else if (!r_x[0]) begin
            w_gx = r_x >> 1;
        end else if (!r_y[0]) begin
            w_gy = r_y >> 1;
        end else if (r_x >= r_y) begin
            w_gx = r_y; w_gy = (r_x - r_y) >> 1;
        end else begin
            w_gy = (r_y - r_x) >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dstart <= 1'b0;
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            if (r_ov && i_pop) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (i_jvalid) begin
                        r_job <= i_job;
                        if (i_job.err) begin
                            r_res.res_num   <= '0;
                            r_res.res_den   <= 63'd1;
                            r_res.div_error <= 1'b1;
                            r_st <= S_OUT;
                        end else if (i_job.func == OP_ADD || i_job.func == OP_SUB) begin
                            r_x <= MAGW'(i_job.da);
                            r_y <= MAGW'(i_job.db);
                            r_k <= '0;
                            r_st <= S_G1;
                        end else begin
                            r_st <= S_M1;
                        end
                    end
                end
                S_G1: begin
                    r_x <= w_gx; r_y <= w_gy; r_k <= w_gk;
                    if (w_gdone) begin
                        r_dvd <= MAGW'(r_job.db);
                        r_dvs <= r_x << r_k[5:0];
                        r_dstart <= 1'b1;
                        r_st <= S_DV1;
                    end
                end
                S_DV1: begin
                    if (w_ddone) begin
                        r_q1 <= w_quo;
                        r_g  <= r_x << r_k[5:0];
                        r_st <= S_M1;
                    end
                end
                S_M1: begin
                    // first products: mag and den for mul/div; for add/sub t1 = na*(db/g), den
                    if (r_job.func == OP_MUL) begin
                        r_mag <= MAGW'(r_job.na) * MAGW'(r_job.nb);
                        r_den <= MAGW'(r_job.da) * MAGW'(r_job.db);
                        r_neg <= r_job.sa ^ r_job.sb;
                        r_st  <= S_G2;
                    end else if (r_job.func == OP_DIV) begin
                        r_mag <= MAGW'(r_job.na) * MAGW'(r_job.db);
                        r_den <= MAGW'(r_job.da) * MAGW'(r_job.nb);
                        r_neg <= r_job.sa ^ r_job.sb;
                        r_st  <= S_G2;
                    end else begin
                        r_t1  <= MAGW'(r_job.na) * MAGW'(r_q1[31:0]);
                        r_den <= MAGW'(r_job.da) * MAGW'(r_q1[31:0]);
                        r_dvd <= MAGW'(r_job.da);
                        r_dvs <= r_g;
                        r_dstart <= 1'b1;
                        r_st  <= S_WAITD;
                    end
                end
                S_WAITD: begin
                    if (w_ddone) begin
                        r_mag <= MAGW'(r_job.nb) * MAGW'(w_quo[31:0]);
                        r_st  <= S_M2;
                    end
                end
                S_M2: begin
                    // r_mag holds t2
                    if (r_job.sa == r_job.sb) begin
                        r_mag <= r_t1 + r_mag; r_neg <= r_job.sa;
                    end else if (r_t1 >= r_mag) begin
                        r_mag <= r_t1 - r_mag; r_neg <= r_job.sa;
                    end else begin
                        r_mag <= r_mag - r_t1; r_neg <= r_job.sb;
                    end
                    r_st <= S_G2;
                end
                S_G2: begin
                    r_x <= r_mag; r_y <= r_den; r_k <= '0;
                    r_st <= S_DVN;
                    if (r_mag == '0) begin
                        r_res.res_num   <= '0;
                        r_res.res_den   <= 63'd1;
                        r_res.div_error <= 1'b0;
                        r_st <= S_OUT;
                    end
                end
                S_DVN: begin
                    r_x <= w_gx; r_y <= w_gy; r_k <= w_gk;
                    if (w_gdone) begin
                        r_g   <= r_x << r_k[5:0];
                        r_dvd <= r_mag;
                        r_dvs <= r_x << r_k[5:0];
                        r_dstart <= 1'b1;
                        r_st <= S_DVD;
                        r_k  <= '0;
                    end
                end
                S_DVD: begin
                    if (w_ddone) begin
                        if (r_k == '0) begin
                            r_mag <= w_quo;
                            r_dvd <= r_den;
                            r_dvs <= r_g;
                            r_dstart <= 1'b1;
                            r_k <= 7'd1;
                        end else begin
                            r_res.res_num   <= r_neg ? (MAGW'(0) - r_mag) : r_mag;
                            r_res.res_den   <= w_quo[62:0];
                            r_res.div_error <= 1'b0;
                            r_st <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ov || i_pop) begin
                        r_out <= r_res;
                        r_ov  <= 1'b1;
                        r_st  <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit.
// Depends on rau_pkg, rau_front, rau_back, rau_divider.
//
// Each transaction carries two signed fractions and an op (add, sub, mul,
// div); the result is reduced to lowest terms, sign on the numerator,
// denominator positive, 0/1 for a zero result. A zero denominator, or
// division by a zero fraction, returns 0/1 with div_error set. The front end
// classifies items into a two-entry queue; the back end works one item at a
// time. An error transaction skips the arithmetic; any other item goes through
// binary GCD steps (on the denominators for add/sub, and on the 64-bit result
// for the reduction), plus two (mul, div) or four (add, sub) passes through
// the single bit-serial divider, two fewer when the result is zero. The result
// register frees the back end once a result is waiting to be popped; the
// next result is held back until that one is taken.
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPW_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_data,
    output logic empty,
    input  logic pop,
    output t_out o_data
);
    logic w_jvalid, w_jtake;
    t_job w_job;

    rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (i_data),
        .o_full  (full),
        .o_jvalid(w_jvalid),
        .o_job   (w_job),
        .i_jtake (w_jtake)
    );

    rau_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_jvalid(w_jvalid),
        .i_job   (w_job),
        .o_jtake (w_jtake),
        .o_empty (empty),
        .o_data  (o_data),
        .i_pop   (pop)
    );
endmodule

### verif/tb_top.sv
// Testbench for rational_arithmetic_unit: directed and random fraction transactions,
// checked against an in-bench predictor through a small scoreboard class.
// Depends on rau_pkg and the RTL of the unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rau_pkg::*;

    localparam int W        = OPW_DEFAULT;
    localparam int N_RANDOM = 1030;

    // Expected results of accepted transactions; checks each popped result in order.
    class frac_scoreboard;
        t_out pending[$];
        int   n_errors;
        int   n_checked;
        int   n_flagged;

        // binary-free Euclid on magnitudes
        static function logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
            logic [63:0] t;
            while (y != 0) begin
                t = y;
                y = x % y;
                x = t;
            end
            return x;
        endfunction

        static function logic [63:0] magnitude(logic [31:0] raw, output logic neg);
            logic signed [63:0] v;
            v = signed'(raw);
            neg = v < 0;
            return neg ? -v : v;
        endfunction

        static function t_out reduce_fraction(t_in it);
            t_out r;
            logic an, ad, bn, bd, sa, sb, neg;
            logic [63:0] na, da, nb, db, g, t1, t2, mag, den;
            na = magnitude(it.a_num, an);
            da = magnitude(it.a_den, ad);
            nb = magnitude(it.b_num, bn);
            db = magnitude(it.b_den, bd);
            sa = an ^ ad;
            sb = bn ^ bd;
            r.res_num = 0;
            r.res_den = 1;
            r.div_error = 0;
            if (da == 0 || db == 0 || (it.func == OP_DIV && nb == 0)) begin
                r.div_error = 1;
                return r;
            end
            case (it.func)
                OP_ADD, OP_SUB: begin
                    if (it.func == OP_SUB) sb = !sb;
                    g = gcd64(da, db);
                    t1 = na * (db / g);
                    t2 = nb * (da / g);
                    den = da * (db / g);
                    if (sa == sb) begin
                        mag = t1 + t2;
                        neg = sa;
                    end else if (t1 >= t2) begin
                        mag = t1 - t2;
                        neg = sa;
                    end else begin
                        mag = t2 - t1;
                        neg = sb;
                    end
                end
                OP_MUL: begin
                    mag = na * nb;
                    den = da * db;
                    neg = sa ^ sb;
                end
                default: begin
                    mag = na * db;
                    den = da * nb;
                    neg = sa ^ sb;
                end
            endcase
            if (mag == 0) return r;
            g = gcd64(mag, den);
            mag = mag / g;
            den = den / g;
            r.res_num = neg ? -mag : mag;
            r.res_den = den[62:0];
            return r;
        endfunction

        function void note_push(t_in it);
            pending.push_back(reduce_fraction(it));
        endfunction

        function void check_pop(t_out got);
            t_out e;
            if (pending.size() == 0) begin
                $error("result with nothing expected: %0d/%0d err=%0b",
                       got.res_num, got.res_den, got.div_error);
                n_errors++;
                return;
            end
            e = pending.pop_front();
            n_checked++;
            if (e.div_error) n_flagged++;
            if (got.res_num !== e.res_num) begin
                $error("res_num: expected %0d, actual %0d", e.res_num, got.res_num);
                n_errors++;
            end
            if (got.res_den !== e.res_den) begin
                $error("res_den: expected %0d, actual %0d", e.res_den, got.res_den);
                n_errors++;
            end
            if (got.div_error !== e.div_error) begin
                $error("div_error: expected %0b, actual %0b", e.div_error, got.div_error);
                n_errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic push = 0;
    logic pop = 0;
    logic full, empty;
    t_in  i_data = '0;
    t_out o_data;

    frac_scoreboard sb = new();
    bit   hold_off = 0;      // receiver stalls for a long stretch while set
    bit   stim_done = 0;
    longint cycle = 0;

    rational_arithmetic_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_data(i_data), .empty(empty), .pop(pop), .o_data(o_data)
    );

    always #2 i_clk = ~i_clk;

    // Watchdog: a wide margin over the worst-case run time, stalls included.
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > 2_000_000) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Receiver: pops on a pattern of its own, checks every accepted transaction.
    int stall_mode = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) sb.check_pop(o_data);
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: pop <= !hold_off;
            1: pop <= !hold_off && ($urandom_range(0, 3) != 0);
            default: pop <= !hold_off && ($urandom_range(0, 3) == 0);
        endcase
    end

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'($urandom_range(0, 12)) - 32'd6;
            4: return 32'($urandom_range(0, 2000)) - 32'd1000;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_in rand_item();
        t_in it;
        it.func  = 2'($urandom_range(0, 3));
        it.a_num = rand_operand();
        it.b_num = rand_operand();
        it.a_den = rand_operand();
        it.b_den = rand_operand();
        // zero denominators are rare so real arithmetic dominates
        if (it.a_den == 0 && $urandom_range(0, 3) != 0) it.a_den = 1;
        if (it.b_den == 0 && $urandom_range(0, 3) != 0) it.b_den = -1;
        return it;
    endfunction

    // Offer one transaction and hold it until it is accepted.
    task automatic send(t_in it);
        push   <= 1;
        i_data <= it;
        do @(posedge i_clk); while (full);
        sb.note_push(it);
    endtask

    task automatic idle_sender(int n);
        push <= 0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        push <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_in mk(logic [1:0] f, int an, int ad, int bn, int bd);
        t_in it;
        it.func = f; it.a_num = an; it.a_den = ad; it.b_num = bn; it.b_den = bd;
        return it;
    endfunction

    initial begin
        t_in directed[$];
        int burst;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // every op, sign mixes, zero results, zero denominators, divide by zero,
        // and the most negative and most positive operands
        directed = '{
            mk(OP_ADD, 1, 2, 1, 3),            mk(OP_SUB, 1, 2, 1, 2),
            mk(OP_MUL, -3, 4, 8, -9),          mk(OP_DIV, 5, -6, -10, 12),
            mk(OP_ADD, 0, 5, 0, -7),           mk(OP_MUL, 0, 1, 9, 4),
            mk(OP_ADD, 1, 0, 1, 1),            mk(OP_SUB, 3, 1, 2, 0),
            mk(OP_DIV, 7, 3, 0, 5),            mk(OP_MUL, 2, 0, 0, 0),
            mk(OP_ADD, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_fffe),
            mk(OP_SUB, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff),
            mk(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1),
            mk(OP_DIV, 32'h8000_0000, 1, 1, 32'h8000_0000),
            mk(OP_MUL, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1),
            mk(OP_DIV, 32'h7fff_ffff, 32'h7fff_fffe, 32'h8000_0000, 32'h7fff_ffff),
            mk(OP_ADD, -1, -1, -1, -1),        mk(OP_SUB, -6, 4, 6, -4),
            mk(OP_DIV, 4, 6, 2, 3),            mk(OP_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1)
        };
        foreach (directed[i]) send(directed[i]);
        drain();

        // long receiver stall with the sender still pushing: fills the queue
        hold_off = 1;
        fork
            begin
                int k;
                for (k = 0; k < 300; k++) @(posedge i_clk);
                hold_off = 0;
            end
            begin
                int k;
                for (k = 0; k < 6; k++) send(rand_item());
                push <= 0;
            end
        join
        drain();   // sender pauses until every result is back

        // random bursts with random gaps
        for (int n = 0; n < N_RANDOM; ) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && n < N_RANDOM; k++, n++) send(rand_item());
            if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 40));
        end
        drain();
        repeat (500) @(posedge i_clk);

        $display("tb_top: %0d results checked, %0d with div_error; all ops, extremes, stalls",
                 sb.n_checked, sb.n_flagged);
        if (sb.n_errors == 0 && sb.pending.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule
